// ===== sv/d8sd_pkg.sv =====
// Shared types, constants and functions of the D8 steepest-descent receiver.
package d8sd_pkg;

	localparam int HEIGHT_BITS = 16;
	localparam int IN_HEIGHT_W = 16;
	localparam int H_W = (HEIGHT_BITS < IN_HEIGHT_W) ? HEIGHT_BITS : IN_HEIGHT_W;
	localparam int INV_W = 16;
	localparam int PROD_W = H_W + INV_W;
	localparam int SLOPE_W = 32;
	localparam int DIR_W = 4;
	localparam int NB_COUNT = 8;
	localparam int CFG_IDX_W = 2;

	localparam logic [DIR_W-1:0] DIR_SELF = 4'd8;

	localparam logic [CFG_IDX_W-1:0] CFG_INV_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INV_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INV_DIAG = 2'd2;

	localparam logic [INV_W-1:0] INV_X_RESET = 16'd65535;
	localparam logic [INV_W-1:0] INV_Y_RESET = 16'd65535;
	localparam logic [INV_W-1:0] INV_DIAG_RESET = 16'd46341;

	typedef enum logic [1:0] {
		DIST_DIAG,
		DIST_Y,
		DIST_X
	} dist_class_t;

	typedef struct packed {
		logic [INV_W-1:0] inv_x;
		logic [INV_W-1:0] inv_y;
		logic [INV_W-1:0] inv_diag;
	} inv_cfg_t;

	typedef struct packed {
		logic [SLOPE_W-1:0] slope;
		logic [DIR_W-1:0]   dir;
	} slope_entry_t;

	function automatic dist_class_t dist_class(input int k);
		dist_class_t c;
		case (k)
			1, 6: c = DIST_Y;
			3, 4: c = DIST_X;
			default: c = DIST_DIAG;
		endcase
		return c;
	endfunction

	function automatic slope_entry_t pick(input slope_entry_t a, input slope_entry_t b);
		slope_entry_t r;
		r = (b.slope > a.slope) ? b : a;
		return r;
	endfunction

endpackage

// ===== sv/d8sd_drop.sv =====
// Stage one: per-neighbor drop below the center cell and lower mask.
module d8sd_drop import d8sd_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [H_W-1:0]                centre,
	input  logic [NB_COUNT-1:0][H_W-1:0]  heights,
	input  logic [NB_COUNT-1:0]           present,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [NB_COUNT-1:0]           lower_s1,
	output logic [NB_COUNT-1:0][H_W-1:0]  drop_s1
);

	logic                         valid_s1;
	logic                         en;
	logic [NB_COUNT-1:0]          lower_d;
	logic [NB_COUNT-1:0][H_W-1:0] drop_d;

	assign en = !valid_s1 || out_ready;
	assign in_ready = en;
	assign out_valid = valid_s1;

	always_comb begin
		for (int k = 0; k < NB_COUNT; k++) begin
			lower_d[k] = present[k] && (heights[k] < centre);
			drop_d[k] = lower_d[k] ? H_W'(centre - heights[k]) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			lower_s1 <= lower_d;
			drop_s1 <= drop_d;
		end
	end

endmodule

// ===== sv/d8sd_mult.sv =====
// Stage two: drop times reciprocal distance for all eight neighbors.
module d8sd_mult import d8sd_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [NB_COUNT-1:0]           lower,
	input  logic [NB_COUNT-1:0][H_W-1:0]  drop,
	input  inv_cfg_t                      inv_cfg,
	output logic                          out_valid,
	input  logic                          out_ready,
	output slope_entry_t [NB_COUNT-1:0]   entry_s2
);

	logic                              valid_s2;
	logic                              en;
	slope_entry_t [NB_COUNT-1:0]       entry_d;
	logic [NB_COUNT-1:0][INV_W-1:0]    inv_k;
	logic [NB_COUNT-1:0][PROD_W-1:0]   prod;

	assign en = !valid_s2 || out_ready;
	assign in_ready = en;
	assign out_valid = valid_s2;

	always_comb begin
		for (int k = 0; k < NB_COUNT; k++) begin
			case (dist_class(k))
				DIST_X: inv_k[k] = inv_cfg.inv_x;
				DIST_Y: inv_k[k] = inv_cfg.inv_y;
				default: inv_k[k] = inv_cfg.inv_diag;
			endcase
			prod[k] = PROD_W'(drop[k]) * PROD_W'(inv_k[k]);
			if (lower[k] && (prod[k] != '0)) begin
				entry_d[k].slope = SLOPE_W'(prod[k]);
				entry_d[k].dir = DIR_W'(k);
			end else begin
				entry_d[k].slope = '0;
				entry_d[k].dir = DIR_SELF;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			entry_s2 <= entry_d;
		end
	end

endmodule

// ===== sv/d8sd_max.sv =====
// Stages three to five: registered maximum tree, earliest neighbor wins ties.
module d8sd_max import d8sd_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  slope_entry_t [NB_COUNT-1:0]   entry,
	output logic                          out_valid,
	input  logic                          out_ready,
	output slope_entry_t                  best_s5
);

	logic                 valid_s3, valid_s4, valid_s5;
	logic                 en3, en4, en5;
	slope_entry_t [3:0]   pair_s3;
	slope_entry_t [1:0]   pair_s4;

	assign en5 = !valid_s5 || out_ready;
	assign en4 = !valid_s4 || en5;
	assign en3 = !valid_s3 || en4;
	assign in_ready = en3;
	assign out_valid = valid_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (en3) begin
				valid_s3 <= in_valid;
			end
			if (en4) begin
				valid_s4 <= valid_s3;
			end
			if (en5) begin
				valid_s5 <= valid_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en3 && in_valid) begin
			for (int i = 0; i < 4; i++) begin
				pair_s3[i] <= pick(entry[2*i], entry[2*i+1]);
			end
		end
		if (en4 && valid_s3) begin
			for (int i = 0; i < 2; i++) begin
				pair_s4[i] <= pick(pair_s3[2*i], pair_s3[2*i+1]);
			end
		end
		if (en5 && valid_s4) begin
			best_s5 <= pick(pair_s4[0], pair_s4[1]);
		end
	end

endmodule

// ===== sv/d8_steepest_descent_receiver.sv =====
// Top level of the D8 steepest-descent receiver.
//
// Input channel: in_valid / in_stall carry one request per raster cell:
// the center height, the eight neighbor heights (nw, n, ne, w, e, sw, s,
// se) and neighbour_present. Output channel: out_valid / out_stall carry
// flow_direction (0..7 neighbor, 8 drains to itself) and steepest_slope
// (Q16.16 drop times reciprocal distance, zero for self).
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 inv_step_x, 1 inv_step_y, 2 inv_step_diag); index 3 is ignored.
// There are five register stages (drop, multiply and three levels of the
// maximum tree), the first one loaded at the accepting edge.
// Throughput is one request per cycle while out_stall is low; eight
// 16x16 multipliers in the second stage work in parallel.
// Reset clears all stage valid bits and loads the reciprocal registers
// with their defaults. When the receiver stalls, the result holds, and
// stages fill up behind it; in_stall rises only once every stage up to
// the first holds a request.
module d8_steepest_descent_receiver import d8sd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [15:0]           centre_height,
	input  logic [15:0]           height_nw,
	input  logic [15:0]           height_n,
	input  logic [15:0]           height_ne,
	input  logic [15:0]           height_w,
	input  logic [15:0]           height_e,
	input  logic [15:0]           height_sw,
	input  logic [15:0]           height_s,
	input  logic [15:0]           height_se,
	input  logic [7:0]            neighbour_present,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [3:0]            flow_direction,
	output logic [31:0]           steepest_slope,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [INV_W-1:0]      cfg_data
);

	inv_cfg_t                      inv_cfg_q;
	logic [NB_COUNT-1:0][H_W-1:0]  heights;
	logic                          drop_ready, drop_valid;
	logic                          mult_ready, mult_valid;
	logic                          max_ready;
	logic [NB_COUNT-1:0]           lower_s1;
	logic [NB_COUNT-1:0][H_W-1:0]  drop_s1;
	slope_entry_t [NB_COUNT-1:0]   entry_s2;
	slope_entry_t                  best_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_cfg_q.inv_x <= INV_X_RESET;
			inv_cfg_q.inv_y <= INV_Y_RESET;
			inv_cfg_q.inv_diag <= INV_DIAG_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_INV_X: inv_cfg_q.inv_x <= cfg_data;
				CFG_INV_Y: inv_cfg_q.inv_y <= cfg_data;
				CFG_INV_DIAG: inv_cfg_q.inv_diag <= cfg_data;
				default: ;
			endcase
		end
	end

	assign heights[0] = H_W'(height_nw);
	assign heights[1] = H_W'(height_n);
	assign heights[2] = H_W'(height_ne);
	assign heights[3] = H_W'(height_w);
	assign heights[4] = H_W'(height_e);
	assign heights[5] = H_W'(height_sw);
	assign heights[6] = H_W'(height_s);
	assign heights[7] = H_W'(height_se);

	assign in_stall = !drop_ready;

	d8sd_drop u_drop (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (drop_ready),
		.centre    (H_W'(centre_height)),
		.heights   (heights),
		.present   (neighbour_present),
		.out_valid (drop_valid),
		.out_ready (mult_ready),
		.lower_s1  (lower_s1),
		.drop_s1   (drop_s1)
	);

	d8sd_mult u_mult (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (drop_valid),
		.in_ready  (mult_ready),
		.lower     (lower_s1),
		.drop      (drop_s1),
		.inv_cfg   (inv_cfg_q),
		.out_valid (mult_valid),
		.out_ready (max_ready),
		.entry_s2  (entry_s2)
	);

	d8sd_max u_max (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mult_valid),
		.in_ready  (max_ready),
		.entry     (entry_s2),
		.out_valid (out_valid),
		.out_ready (!out_stall),
		.best_s5   (best_s5)
	);

	assign flow_direction = best_s5.dir;
	assign steepest_slope = best_s5.slope;

endmodule

// ===== sv/d8sd_checker.sv =====
// Port-level checker for the D8 steepest-descent receiver, with its bind.
module d8sd_checker import d8sd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_stall,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [3:0]  flow_direction,
	input  logic [31:0] steepest_slope
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(flow_direction)
			&& $stable(steepest_slope))
		else $error("stalled result changed");

	a_self_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (flow_direction == DIR_SELF) |-> steepest_slope == '0)
		else $error("self drainage with nonzero slope");

	a_nb_positive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (flow_direction < DIR_SELF) |-> steepest_slope != '0)
		else $error("neighbour chosen with zero slope");

	a_dir_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> flow_direction <= DIR_SELF)
		else $error("direction code out of range");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled while output drains");

endmodule

bind d8_steepest_descent_receiver d8sd_checker u_d8sd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.flow_direction (flow_direction),
	.steepest_slope (steepest_slope)
);
